// ===== rtl/core/sha1h_pkg.sv =====
// shared types, constants and helper functions of the sha1 stream hasher
package sha1h_pkg;

   localparam int ByteBits   = 8;
   localparam int WordBits   = 32;
   localparam int BlockBits  = 512;
   localparam int CountBits  = 64;
   localparam int FillBits   = 6;
   localparam int RoundBits  = 7;
   localparam int IndexBits  = 3;
   localparam int NumHash    = 5;

   localparam logic [FillBits-1:0]  FillLast   = 6'd63;
   localparam logic [FillBits-1:0]  FillLenPos = 6'd56;
   localparam logic [RoundBits-1:0] RoundLast  = 7'd79;
   localparam logic [IndexBits-1:0] IndexLast  = 3'd4;
   localparam logic [ByteBits-1:0]  PadMark    = 8'h80;
   localparam logic [CountBits-1:0] BitsPerByte = 64'd8;

   localparam logic [WordBits-1:0] InitHash [NumHash] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [1:0] {
      PHASE_CHOOSE,
      PHASE_PARITY_LO,
      PHASE_MAJORITY,
      PHASE_PARITY_HI
   } round_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_INPUT,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic                 shift_en;
      byte_sel_type         shift_sel;
      logic                 count_byte;
      logic                 load_work;
      logic                 round_en;
      logic [RoundBits-1:0] round;
      logic                 add_hash;
      logic                 restart;
      logic [IndexBits-1:0] word_index;
   } ctrl_cmd_type;

   function automatic round_phase_type round_phase(input logic [RoundBits-1:0] rnd);
      round_phase_type ph;
      if (rnd < 7'd20) begin
         ph = PHASE_CHOOSE;
      end else if (rnd < 7'd40) begin
         ph = PHASE_PARITY_LO;
      end else if (rnd < 7'd60) begin
         ph = PHASE_MAJORITY;
      end else begin
         ph = PHASE_PARITY_HI;
      end
      return ph;
   endfunction

   function automatic logic [WordBits-1:0] round_key(input round_phase_type ph);
      logic [WordBits-1:0] k;
      case (ph)
         PHASE_CHOOSE:    k = 32'h5A827999;
         PHASE_PARITY_LO: k = 32'h6ED9EBA1;
         PHASE_MAJORITY:  k = 32'h8F1BBCDC;
         PHASE_PARITY_HI: k = 32'hCA62C1D6;
         default:         k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/sha1h_ifs.sv =====
// valid/ready channel interfaces for the byte input and the digest output
interface sha1h_req_if import sha1h_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] data_byte;
   logic                byte_present;
   logic                end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1h_rsp_if import sha1h_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordBits-1:0]  digest_word;
   logic [IndexBits-1:0] word_index;
   logic                 last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha1h_datapath.sv =====
// block shift line, round registers, hash words and bit counter of the hasher
module sha1h_datapath import sha1h_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic [ByteBits-1:0] data_byte,
   output logic [WordBits-1:0] digest_word
);

   logic [BlockBits-1:0] blk_ff, blk_in;
   logic [WordBits-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WordBits-1:0]  a_in, b_in, c_in, d_in, e_in;
   logic [WordBits-1:0]  hash_ff [NumHash];
   logic [WordBits-1:0]  hash_in [NumHash];
   logic [CountBits-1:0] bits_ff, bits_in;

   logic [ByteBits-1:0]  shift_byte;
   logic [WordBits-1:0]  w_cur, w_mix, w_next, f_val, t_val;
   round_phase_type      phase;

   // word k of the block sits at the top end, word 0 first
   assign w_cur = blk_ff[BlockBits-1 -: WordBits];
   assign w_mix = blk_ff[BlockBits-1-WordBits*13 -: WordBits]
                ^ blk_ff[BlockBits-1-WordBits*8 -: WordBits]
                ^ blk_ff[BlockBits-1-WordBits*2 -: WordBits]
                ^ w_cur;
   assign w_next = {w_mix[WordBits-2:0], w_mix[WordBits-1]};

   assign phase = round_phase(cmd.round);

   always_comb begin
      case (phase)
         PHASE_CHOOSE:   f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         PHASE_MAJORITY: f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:        f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = {a_ff[WordBits-6:0], a_ff[WordBits-1 -: 5]} + f_val + e_ff
                + round_key(phase) + w_cur;

   always_comb begin
      case (cmd.shift_sel)
         SEL_INPUT: shift_byte = data_byte;
         SEL_MARK:  shift_byte = PadMark;
         SEL_ZERO:  shift_byte = '0;
         SEL_LEN:   shift_byte = bits_ff[CountBits-1 -: ByteBits];
         default:   shift_byte = '0;
      endcase
   end

   always_comb begin
      blk_in = blk_ff;
      if (cmd.shift_en) begin
         blk_in = {blk_ff[BlockBits-ByteBits-1:0], shift_byte};
      end else if (cmd.round_en) begin
         // rolling schedule: the next word enters at the bottom each round
         blk_in = {blk_ff[BlockBits-WordBits-1:0], w_next};
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_work) begin
         a_in = hash_ff[0];
         b_in = hash_ff[1];
         c_in = hash_ff[2];
         d_in = hash_ff[3];
         e_in = hash_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[WordBits-1:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      hash_in = hash_ff;
      if (cmd.restart) begin
         hash_in = InitHash;
      end else if (cmd.add_hash) begin
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
      end
   end

   always_comb begin
      bits_in = bits_ff;
      if (cmd.restart) begin
         bits_in = '0;
      end else if (cmd.count_byte) begin
         bits_in = bits_ff + BitsPerByte;
      end else if (cmd.shift_en && cmd.shift_sel == SEL_LEN) begin
         // length goes out most significant byte first
         bits_in = {bits_ff[CountBits-ByteBits-1:0], {ByteBits{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      if (reset) begin
         hash_ff <= InitHash;
         bits_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         bits_ff <= bits_in;
      end
   end

   always_comb begin
      case (cmd.word_index)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         default: digest_word = hash_ff[4];
      endcase
   end

endmodule

// ===== rtl/core/sha1h_ctrl.sv =====
// sequencer for byte intake, padding, rounds and digest output
module sha1h_ctrl import sha1h_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 byte_present,
   input  logic                 end_of_message,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IndexBits-1:0] word_index,
   output logic                 last_word,
   output ctrl_cmd_type         cmd
);

   state_type            state_ff, state_in;
   state_type            resume_ff, resume_in;
   logic [FillBits-1:0]  fill_ff, fill_in;
   logic [RoundBits-1:0] round_ff, round_in;
   logic [IndexBits-1:0] idx_ff, idx_in;

   logic accept;
   logic fill_full;

   assign accept    = req_valid && state_ff == ST_IDLE;
   assign fill_full = fill_ff == FillLast;

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (byte_present && fill_full) begin
                  state_in  = ST_LOAD;
                  resume_in = end_of_message ? ST_PAD_MARK : ST_IDLE;
               end else if (end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == RoundLast) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: state_in = resume_ff;
         ST_PAD_MARK: begin
            state_in = ST_PAD_ZERO;
            if (fill_full) begin
               state_in  = ST_LOAD;
               resume_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (fill_ff == FillLenPos) begin
               state_in = ST_PAD_LEN;
            end else if (fill_full) begin
               // length did not fit: close this block, pad a fresh one
               state_in  = ST_LOAD;
               resume_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            if (fill_full) begin
               state_in  = ST_LOAD;
               resume_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready && idx_ff == IndexLast) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd            = '0;
      cmd.shift_sel  = SEL_INPUT;
      cmd.round      = round_ff;
      cmd.word_index = idx_ff;
      fill_in        = fill_ff;
      round_in       = round_ff;
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && byte_present) begin
               cmd.shift_en   = 1'b1;
               cmd.count_byte = 1'b1;
               fill_in        = fill_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            round_in      = '0;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 1'b1;
         end
         ST_ADD: cmd.add_hash = 1'b1;
         ST_PAD_MARK: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SEL_MARK;
            fill_in       = fill_ff + 1'b1;
         end
         ST_PAD_ZERO: begin
            if (fill_ff != FillLenPos) begin
               cmd.shift_en  = 1'b1;
               cmd.shift_sel = SEL_ZERO;
               fill_in       = fill_ff + 1'b1;
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SEL_LEN;
            fill_in       = fill_ff + 1'b1;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == IndexLast) begin
                  idx_in      = '0;
                  cmd.restart = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign word_index = idx_ff;
   assign last_word  = idx_ff == IndexLast;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= ST_IDLE;
         fill_ff   <= '0;
         round_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         fill_ff   <= fill_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// top level of the sha1 stream hasher: controller, datapath and checks
//
//   channel   direction  payload                                    handshake
//   req_ch    in         data_byte, byte_present, end_of_message    valid/ready
//   rsp_ch    out        digest_word, word_index, last_word         valid/ready
//
// a word that fills no block and ends no message keeps the block idle
// each full 64-byte block is compressed in the single round unit
// (load, 80 rounds, hash add); padding shifts one byte per cycle while no
// block compresses; end of message pads around one or two blocks, with a
// pause at byte 56 before the length, then five digest words, one per
// accepted output cycle
// reset is synchronous and restores the initial hash with an empty message
// input is held off while the block is compressing, padding or emitting
module sha1_stream_hasher import sha1h_pkg::*; (
   input logic        clock,
   input logic        reset,
   sha1h_req_if.sink   req_ch,
   sha1h_rsp_if.source rsp_ch
);

   ctrl_cmd_type         cmd;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [IndexBits-1:0] word_index;
   logic                 last_word;
   logic [WordBits-1:0]  digest_word;

   sha1h_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .byte_present   (req_ch.byte_present),
      .end_of_message (req_ch.end_of_message),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ch.ready),
      .word_index     (word_index),
      .last_word      (last_word),
      .cmd            (cmd)
   );

   sha1h_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_ch.data_byte),
      .digest_word (digest_word)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.digest_word = digest_word;
   assign rsp_ch.word_index  = word_index;
   assign rsp_ch.last_word   = last_word;

   // no input word is taken while a digest is being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("input accepted during digest output");

   // digest words come out in order with no gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_word |=>
         rsp_ch.valid && rsp_ch.word_index == $past(rsp_ch.word_index) + 3'd1)
      else $error("digest word sequence broken");

   // after the final word the block is ready for a new message
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word |=>
         req_ch.ready && !rsp_ch.valid && rsp_ch.word_index == 3'd0)
      else $error("no return to idle after final digest word");

   // a fresh digest always starts with the first hash word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> rsp_ch.word_index == 3'd0)
      else $error("digest output started mid sequence");

endmodule

// ===== tb/sv/tb_sha1_stream_hasher.sv =====
// sha1 hasher testbench: directed and random byte streams against a behavioral digest model
module tb_sha1_stream_hasher import sha1h_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 3000;
   localparam int SettleCycles = 200;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic [WordBits-1:0]  digest_word;
      logic [IndexBits-1:0] word_index;
      logic                 last_word;
   } digest_out_type;

   logic clock;
   logic reset;

   sha1h_req_if req_ch ();
   sha1h_rsp_if rsp_ch ();

   sha1_stream_hasher uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // behavioral digest state
   logic [WordBits-1:0]  hash_state [NumHash];
   logic [ByteBits-1:0]  block_bytes [64];
   int                   fill;
   logic [CountBits-1:0] bit_total;
   digest_out_type       digest_queue [$];

   int errors = 0;
   int idle_cycles = 0;
   int hold_request = 0;
   int rsp_stall = 0;
   bit no_idle = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [WordBits-1:0] rol(input logic [WordBits-1:0] x, input int n);
      return (x << n) | (x >> (WordBits - n));
   endfunction

   function automatic void hash_restart();
      hash_state = InitHash;
      fill = 0;
      bit_total = '0;
   endfunction

   function automatic void compress_block();
      logic [WordBits-1:0] w [16];
      logic [WordBits-1:0] a, b, c, d, e, f, k, t, wr;
      for (int r = 0; r < 16; r++) begin
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            // rolling 16-word schedule
            wr = rol(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            w[r%16] = wr;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + wr;
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endfunction

   // update the digest state with one accepted word, queue the digest at end of message
   function automatic void hash_word(input logic [ByteBits-1:0] data, input logic present,
                                     input logic eom);
      int pos;
      logic [CountBits-1:0] total;
      if (present) begin
         block_bytes[fill] = data;
         fill++;
         if (fill == 64) begin
            compress_block();
            bit_total += 64'd512;
            fill = 0;
         end
      end
      if (eom) begin
         total = bit_total + 64'(fill) * 64'd8;
         block_bytes[fill] = PadMark;
         pos = fill + 1;
         // no room for the length: zero fill and an extra block
         if (pos > 56) begin
            while (pos < 64) begin
               block_bytes[pos] = '0;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            block_bytes[pos] = '0;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            block_bytes[56+i] = total[63-8*i -: 8];
         end
         compress_block();
         for (int n = 0; n < NumHash; n++) begin
            digest_queue.push_back('{digest_word: hash_state[n],
                                     word_index: IndexBits'(n),
                                     last_word: (n == NumHash - 1)});
         end
         hash_restart();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [WordBits-1:0] got,
                                  input logic [WordBits-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(12, 48);
   endfunction

   function automatic int sender_gap();
      if (no_idle || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return gap_length();
   endfunction

   // offer one word at the falling edge, hold it until accepted
   task automatic send_word(input logic [ByteBits-1:0] data, input logic present,
                            input logic eom);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data_byte = data;
      req_ch.byte_present = present;
      req_ch.end_of_message = eom;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      hash_word(data, present, eom);
      @(negedge clock);
   endtask

   task automatic wait_for_digests();
      req_ch.valid = 1'b0;
      while (digest_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall = hold_request;
            hold_request = 0;
         end
         if (rsp_stall > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_stall--;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            rsp_stall = gap_length() - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // compare each digest word with the oldest queued one
   always @(posedge clock) begin
      digest_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_ch.digest_word, '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_ch.digest_word !== want.digest_word) begin
               report_mismatch("digest_word", rsp_ch.digest_word, want.digest_word);
            end
            if (rsp_ch.word_index !== want.word_index) begin
               report_mismatch("word_index", 32'(rsp_ch.word_index), 32'(want.word_index));
            end
            if (rsp_ch.last_word !== want.last_word) begin
               report_mismatch("last_word", 32'(rsp_ch.last_word), 32'(want.last_word));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic test_empty_message();
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hFF, 1'b0, 1'b1);
   endtask

   // also confirms the digest model on a published vector
   task automatic test_known_vector();
      logic [WordBits-1:0] abc_digest [NumHash];
      int base;
      abc_digest = '{32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D};
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      base = digest_queue.size() - NumHash;
      for (int n = 0; n < NumHash; n++) begin
         if (digest_queue[base+n].digest_word !== abc_digest[n]) begin
            report_mismatch("model abc digest", digest_queue[base+n].digest_word, abc_digest[n]);
         end
      end
   endtask

   task automatic test_ignored_bytes();
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h12, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h34, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h7F, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1);
   endtask

   // receiver holds off while back-to-back messages pile up behind the digest
   task automatic test_output_backpressure();
      no_idle = 1'b1;
      hold_request = HoldCycles;
      for (int m = 0; m < 3; m++) begin
         send_word(8'($urandom), 1'b1, 1'b0);
         send_word(8'($urandom), 1'b1, 1'b1);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause();
      send_word(8'h5A, 1'b1, 1'b0);
      send_word(8'hA5, 1'b1, 1'b1);
      wait_for_digests();
      send_word(8'h3C, 1'b1, 1'b1);
   endtask

   task automatic test_random_streams();
      int sent;
      int messages;
      int len;
      int pick;
      bit end_with_byte;
      sent = 0;
      messages = 0;
      while (sent < 300 || messages < 12) begin
         no_idle = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 9);
         // mostly short messages, some near the padding boundaries
         if (pick < 7) begin
            len = $urandom_range(0, 12);
         end else if (pick < 9) begin
            len = $urandom_range(52, 66);
         end else begin
            len = $urandom_range(110, 130);
         end
         end_with_byte = 1'($urandom_range(0, 1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
            sent++;
         end
         if (len == 0 || !end_with_byte) begin
            send_word(8'($urandom), 1'b0, 1'b1);
            sent++;
         end
         messages++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.byte_present = 1'b0;
      req_ch.end_of_message = 1'b0;
      hash_restart();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_message();
      test_known_vector();
      test_ignored_bytes();
      test_byte_extremes();
      test_output_backpressure();
      test_drain_pause();
      test_random_streams();

      wait_for_digests();
      repeat (SettleCycles) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sha1_stream_hasher.f =====
rtl/core/sha1h_pkg.sv
rtl/core/sha1h_ifs.sv
rtl/core/sha1h_datapath.sv
rtl/core/sha1h_ctrl.sv
rtl/core/sha1_stream_hasher.sv
tb/sv/tb_sha1_stream_hasher.sv
